// File: hdl/tpba_pkg.sv
`timescale 1ns / 1ps

package tpba_pkg;

   localparam int SMALL_SLOTS_DEF = 8;
   localparam int LARGE_SLOTS_DEF = 8;
   localparam int SMALL_BYTES_DEF = 16;
   localparam int LARGE_BYTES_DEF = 64;

   localparam int CODE_W = 4;
   localparam int ADDR_W = 10;
   localparam int CALC_W = 16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic SIZE_SMALL = 1'b0;
   localparam logic SIZE_LARGE = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_NO_ROOM = 1'b1;

   typedef struct packed {
      logic              status;
      logic [CODE_W-1:0] slot_code;
      logic [ADDR_W-1:0] byte_address;
      logic              pair_used;
   } rsp_type;

endpackage

// File: hdl/tpba_alloc_core.sv
`timescale 1ns / 1ps

module tpba_alloc_core import tpba_pkg::*; #(
   parameter int SMALL_SLOTS = SMALL_SLOTS_DEF,
   parameter int LARGE_SLOTS = LARGE_SLOTS_DEF,
   parameter int SMALL_BYTES = SMALL_BYTES_DEF,
   parameter int LARGE_BYTES = LARGE_BYTES_DEF
) (
   input  logic                   command,
   input  logic                   size_class,
   input  logic [CODE_W-1:0]      free_slot,
   input  logic                   free_pair,
   input  logic [SMALL_SLOTS-1:0] small_occ,
   input  logic [LARGE_SLOTS-1:0] large_occ,
   output logic [SMALL_SLOTS-1:0] small_occ_in,
   output logic [LARGE_SLOTS-1:0] large_occ_in,
   output rsp_type                result
);

   localparam logic [CODE_W-1:0] SMALL_CODE = CODE_W'(SMALL_SLOTS);
   localparam logic [CODE_W-1:0] LARGE_CODE = CODE_W'(LARGE_SLOTS);
   localparam logic [CALC_W-1:0] LARGE_BASE = CALC_W'(SMALL_SLOTS * SMALL_BYTES);

   logic              small_full;
   logic              large_full;
   logic [CODE_W-1:0] small_loc;
   logic [CODE_W-1:0] large_loc;
   logic [CODE_W-1:0] pair_loc;
   logic              pair_found;
   logic [CODE_W-1:0] large_idx;
   logic [CALC_W-1:0] small_addr;
   logic [CALC_W-1:0] large_addr;
   logic [CALC_W-1:0] pair_addr;

   assign small_full = &small_occ;
   assign large_full = &large_occ;
   assign large_idx  = free_slot - SMALL_CODE;

   // priority encoders, lowest free slot wins
   always_comb begin
      small_loc = '0;
      for (int i = SMALL_SLOTS - 1; i >= 0; i--) begin
         if (!small_occ[i]) small_loc = CODE_W'(i);
      end
   end

   always_comb begin
      large_loc = '0;
      for (int i = LARGE_SLOTS - 1; i >= 0; i--) begin
         if (!large_occ[i]) large_loc = CODE_W'(i);
      end
   end

   always_comb begin
      pair_loc   = '0;
      pair_found = 1'b0;
      for (int i = SMALL_SLOTS - 2; i >= 0; i--) begin
         if (!small_occ[i] && !small_occ[i+1]) begin
            pair_loc   = CODE_W'(i);
            pair_found = 1'b1;
         end
      end
   end

   assign small_addr = CALC_W'(small_loc) * CALC_W'(SMALL_BYTES);
   assign large_addr = LARGE_BASE + CALC_W'(large_loc) * CALC_W'(LARGE_BYTES);
   assign pair_addr  = CALC_W'(pair_loc) * CALC_W'(SMALL_BYTES);

   always_comb begin
      small_occ_in = small_occ;
      large_occ_in = large_occ;
      result       = '0;
      if (command == CMD_FREE) begin
         if (free_slot < SMALL_CODE) begin
            small_occ_in = small_occ & ~(SMALL_SLOTS'(1) << free_slot);
            if (free_pair && (CALC_W'(free_slot) + 1'b1 < CALC_W'(SMALL_SLOTS))) begin
               small_occ_in = small_occ_in & ~(SMALL_SLOTS'(2) << free_slot);
            end
         end else if (large_idx < LARGE_CODE) begin
            large_occ_in = large_occ & ~(LARGE_SLOTS'(1) << large_idx);
         end
      end else if (size_class == SIZE_SMALL) begin
         if (!small_full) begin
            small_occ_in        = small_occ | (SMALL_SLOTS'(1) << small_loc);
            result.slot_code    = small_loc;
            result.byte_address = small_addr[ADDR_W-1:0];
         end else if (!large_full) begin
            large_occ_in        = large_occ | (LARGE_SLOTS'(1) << large_loc);
            result.slot_code    = SMALL_CODE + large_loc;
            result.byte_address = large_addr[ADDR_W-1:0];
         end else begin
            result.status = STATUS_NO_ROOM;
         end
      end else begin
         if (!large_full) begin
            large_occ_in        = large_occ | (LARGE_SLOTS'(1) << large_loc);
            result.slot_code    = SMALL_CODE + large_loc;
            result.byte_address = large_addr[ADDR_W-1:0];
         end else if (pair_found) begin
            small_occ_in        = small_occ | (SMALL_SLOTS'(3) << pair_loc);
            result.slot_code    = pair_loc;
            result.byte_address = pair_addr[ADDR_W-1:0];
            result.pair_used    = 1'b1;
         end else begin
            result.status = STATUS_NO_ROOM;
         end
      end
   end

endmodule

// File: hdl/two_pool_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// path: a request is accepted into the input register, then moves to the response register,
// where the response becomes valid; the input register takes an item when empty or moving on
// throughput: one item per cycle while the response is not stalled; occupancy maps update
// as an item moves to the response register; a stalled response holds the pipe
// reset: synchronous, active high; clears valids and both occupancy maps (every slot free)

module two_pool_bitmap_allocator_top import tpba_pkg::*; #(
   parameter int SMALL_SLOTS = SMALL_SLOTS_DEF,
   parameter int LARGE_SLOTS = LARGE_SLOTS_DEF,
   parameter int SMALL_BYTES = SMALL_BYTES_DEF,
   parameter int LARGE_BYTES = LARGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // free_slot[3:0], free_pair[4], zero fill
   input  logic [1:0]  req_tuser,   // command[0], size_class[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // slot_code[3:0], byte_address[13:4], pair_used[14], zero fill
   output logic        rsp_tuser    // status[0]
);

   logic                   in_valid_ff;
   logic                   command_ff;
   logic                   size_class_ff;
   logic [CODE_W-1:0]      free_slot_ff;
   logic                   free_pair_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [SMALL_SLOTS-1:0] small_occ_ff;
   logic [SMALL_SLOTS-1:0] small_occ_in;
   logic [LARGE_SLOTS-1:0] large_occ_ff;
   logic [LARGE_SLOTS-1:0] large_occ_in;
   logic                   advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         command_ff    <= req_tuser[0];
         size_class_ff <= req_tuser[1];
         free_slot_ff  <= req_tdata[3:0];
         free_pair_ff  <= req_tdata[4];
      end
   end

   tpba_alloc_core #(
      .SMALL_SLOTS (SMALL_SLOTS),
      .LARGE_SLOTS (LARGE_SLOTS),
      .SMALL_BYTES (SMALL_BYTES),
      .LARGE_BYTES (LARGE_BYTES)
   ) u_core (
      .command      (command_ff),
      .size_class   (size_class_ff),
      .free_slot    (free_slot_ff),
      .free_pair    (free_pair_ff),
      .small_occ    (small_occ_ff),
      .large_occ    (large_occ_ff),
      .small_occ_in (small_occ_in),
      .large_occ_in (large_occ_in),
      .result       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         small_occ_ff <= '0;
         large_occ_ff <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            small_occ_ff <= small_occ_in;
            large_occ_ff <= large_occ_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {1'b0, rsp_ff.pair_used, rsp_ff.byte_address, rsp_ff.slot_code};

   // occupancy maps come out of reset empty
   assert property (@(posedge clock) $past(reset) |-> (small_occ_ff == '0 && large_occ_ff == '0))
      else $error("occupancy not cleared by reset");

   // a refused allocation leaves both maps untouched
   assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.status == STATUS_NO_ROOM) |=>
      ($stable(small_occ_ff) && $stable(large_occ_ff)))
      else $error("no-room allocation changed occupancy");

   // a pair is only taken for a large item once the large pool is full
   assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.pair_used) |->
      (command_ff == CMD_ALLOC && size_class_ff == SIZE_LARGE && (&large_occ_ff)))
      else $error("pair used outside large-pool overflow");

   // a successful allocation takes exactly one slot, or two for a pair
   assert property (@(posedge clock) disable iff (reset)
      (advance && command_ff == CMD_ALLOC && rsp_in.status == STATUS_DONE) |=>
      ($countones(small_occ_ff) + $countones(large_occ_ff) ==
       $countones($past(small_occ_ff)) + $countones($past(large_occ_ff)) + 1
       + int'($past(rsp_in.pair_used))))
      else $error("allocation did not take the right number of slots");

   // a refused allocation reports no slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_NO_ROOM) |->
      (rsp_ff.slot_code == '0 && rsp_ff.byte_address == '0 && !rsp_ff.pair_used))
      else $error("no-room response carries slot data");

endmodule

// File: tb/slot_grant_checker.sv
`timescale 1ns / 1ps

module slot_grant_checker import tpba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // free_slot[3:0], free_pair[4], zero fill
   input  logic [1:0]  req_tuser,   // command[0], size_class[1]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // slot_code[3:0], byte_address[13:4], pair_used[14], zero fill
   input  logic        rsp_tuser,   // status[0]
   output int          fail_count,
   output int          grants_pending
);

   localparam int N_SMALL = SMALL_SLOTS_DEF;
   localparam int N_LARGE = LARGE_SLOTS_DEF;
   localparam int B_SMALL = SMALL_BYTES_DEF;
   localparam int B_LARGE = LARGE_BYTES_DEF;

   logic [7:0] small_taken;
   logic [7:0] large_taken;
   rsp_type    grants_due[$];

   initial fail_count = 0;

   function automatic int first_clear(input logic [7:0] map, input int slots);
      for (int i = 0; i < slots; i++) begin
         if (!map[i]) return i;
      end
      return slots;
   endfunction

   function automatic int first_clear_pair(input logic [7:0] map, input int slots);
      for (int i = 0; i + 1 < slots; i++) begin
         if (!map[i] && !map[i+1]) return i;
      end
      return slots;
   endfunction

   // updates the occupancy maps as the block does
   function automatic rsp_type predict_grant(input logic cmd, input logic size,
                                             input logic [3:0] slot, input logic pair);
      rsp_type g;
      int      loc;
      int      addr;
      logic    small_full;
      logic    large_full;
      g = '0;
      addr = 0;
      small_full = (first_clear(small_taken, N_SMALL) == N_SMALL);
      large_full = (first_clear(large_taken, N_LARGE) == N_LARGE);
      if (cmd == CMD_FREE) begin
         if (int'(slot) < N_SMALL) begin
            small_taken[slot] = 1'b0;
            if (pair && int'(slot) + 1 < N_SMALL) small_taken[slot+1] = 1'b0;
         end else if (int'(slot) - N_SMALL < N_LARGE) begin
            large_taken[int'(slot) - N_SMALL] = 1'b0;
         end
      end else if (size == SIZE_SMALL && !small_full) begin
         loc = first_clear(small_taken, N_SMALL);
         small_taken[loc] = 1'b1;
         g.slot_code = CODE_W'(loc);
         addr = loc * B_SMALL;
      end else if (!large_full) begin
         loc = first_clear(large_taken, N_LARGE);
         large_taken[loc] = 1'b1;
         g.slot_code = CODE_W'(N_SMALL + loc);
         addr = N_SMALL * B_SMALL + loc * B_LARGE;
      end else if (size == SIZE_LARGE &&
                   first_clear_pair(small_taken, N_SMALL) < N_SMALL) begin
         loc = first_clear_pair(small_taken, N_SMALL);
         small_taken[loc] = 1'b1;
         small_taken[loc+1] = 1'b1;
         g.slot_code = CODE_W'(loc);
         addr = loc * B_SMALL;
         g.pair_used = 1'b1;
      end else begin
         g.status = STATUS_NO_ROOM;
      end
      g.byte_address = ADDR_W'(addr);
      return g;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         small_taken = '0;
         large_taken = '0;
         grants_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               $display("%0t ns: unexpected item, actual status %0d code %0d addr %0d pair %0d",
                        $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[13:4], rsp_tdata[14]);
               fail_count++;
            end else begin
               want = grants_due.pop_front();
               compare_field("status", int'(want.status), int'(rsp_tuser));
               compare_field("slot_code", int'(want.slot_code), int'(rsp_tdata[3:0]));
               compare_field("byte_address", int'(want.byte_address), int'(rsp_tdata[13:4]));
               compare_field("pair_used", int'(want.pair_used), int'(rsp_tdata[14]));
            end
         end
         if (req_tvalid && req_tready)
            grants_due.push_back(predict_grant(req_tuser[0], req_tuser[1],
                                               req_tdata[3:0], req_tdata[4]));
      end
      grants_pending = grants_due.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb import tpba_pkg::*;;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // free_slot[3:0], free_pair[4], zero fill
   logic [1:0]  req_tuser;   // command[0], size_class[1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // slot_code[3:0], byte_address[13:4], pair_used[14], zero fill
   logic        rsp_tuser;   // status[0]
   int          fail_count;
   int          grants_pending;
   logic        rsp_moved = 1'b0;
   logic        send_burst = 1'b0;
   logic        take_burst = 1'b0;

   two_pool_bitmap_allocator_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   slot_grant_checker grant_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .grants_pending(grants_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_moved <= !reset && rsp_tvalid && rsp_tready;
   end

   always @(negedge clock) begin
      int hold;
      if (reset) begin
         hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_moved) begin
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
            hold = take_burst ? 0 : $urandom_range(0, 19);
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_item(input logic cmd, input logic size,
                            input logic [3:0] slot, input logic pair);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, pair, slot};
      req_tuser  <= {size, cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      int alloc_weight;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the small pool, then spill a small item into the large pool
      repeat (9) send_item(CMD_ALLOC, SIZE_SMALL, 4'd0, 1'b0);
      repeat (7) send_item(CMD_ALLOC, SIZE_LARGE, 4'd15, 1'b1);
      // everything taken
      send_item(CMD_ALLOC, SIZE_SMALL, 4'd0, 1'b0);
      send_item(CMD_ALLOC, SIZE_LARGE, 4'd0, 1'b0);
      // pair free at the last small slot clears only that slot
      send_item(CMD_FREE, SIZE_SMALL, 4'd7, 1'b1);
      send_item(CMD_FREE, SIZE_LARGE, 4'd2, 1'b1);
      send_item(CMD_ALLOC, SIZE_LARGE, 4'd0, 1'b0);
      // pair flag on a large slot, then a free of a slot not taken
      send_item(CMD_FREE, SIZE_SMALL, 4'd15, 1'b1);
      send_item(CMD_FREE, SIZE_SMALL, 4'd15, 1'b0);
      send_item(CMD_FREE, SIZE_LARGE, 4'd0, 1'b0);
      send_item(CMD_ALLOC, SIZE_LARGE, 4'd0, 1'b0);
      send_item(CMD_ALLOC, SIZE_SMALL, 4'd0, 1'b0);

      // phases that lean toward filling, draining or neither
      for (int phase = 0; phase < 25; phase++) begin
         case ($urandom_range(0, 2))
            0: alloc_weight = 85;
            1: alloc_weight = 30;
            default: alloc_weight = 55;
         endcase
         send_burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 50; n++) begin
            send_item(($urandom_range(1, 100) <= alloc_weight) ? CMD_ALLOC : CMD_FREE,
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
         end
      end
      req_tvalid <= 1'b0;

      while (grants_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
